// ===== rtl/bsbt_pkg.sv =====
// ----------------------------------------------------------------------------
// Block slot barrier tracker package
// Shared constants, command and status codes, and the word types of both
// channels.
// ----------------------------------------------------------------------------
package bsbt_pkg;

    // Default configuration.
    localparam int DEF_SUBCORES          = 4;
    localparam int DEF_WARPS_PER_SUBCORE = 8;
    localparam int DEF_BLOCK_SLOTS       = 8;
    localparam int DEF_PC_BITS           = 32;
    localparam int DEF_HW_WARPS          = 32;

    // Commands.
    localparam logic [1:0] CMD_ARRIVE  = 2'd0;
    localparam logic [1:0] CMD_BARRIER = 2'd1;
    localparam logic [1:0] CMD_END     = 2'd2;
    localparam logic [1:0] CMD_NONE    = 2'd3;

    // Status codes.
    localparam logic [1:0] STATUS_OK          = 2'd0;
    localparam logic [1:0] STATUS_NO_WARP     = 2'd1;
    localparam logic [1:0] STATUS_BAD_SLOT    = 2'd2;
    localparam logic [1:0] STATUS_PC_MISMATCH = 2'd3;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [1:0]  subcore_index;
        logic [2:0]  local_warp;
        logic [2:0]  slot_index;
        logic [4:0]  warp_in_block;
        logic [31:0] barrier_pc;
    } in_word_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [4:0]  assigned_warp;
        logic        hold_valid;
        logic [4:0]  hold_warp;
        logic [31:0] release_mask;
        logic        finish_valid;
        logic [2:0]  finish_slot;
        logic [4:0]  finish_warp;
        logic        slot_freed;
    } out_word_t;

    // Result of the round-robin idle warp search.
    typedef struct packed {
        logic       found;
        logic [4:0] warp;
    } pick_t;

endpackage

// ===== rtl/bsbt_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bsbt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/bsbt_warp_pick.sv =====
// ----------------------------------------------------------------------------
// Round-robin idle warp picker
// Finds the first idle hardware warp after the last one assigned, wrapping
// round the pool.
// ----------------------------------------------------------------------------
module bsbt_warp_pick #(
    parameter int HW_WARPS = bsbt_pkg::DEF_HW_WARPS
) (
    input  logic [31:0]    busy_mask,
    input  logic [4:0]     last_warp,
    output bsbt_pkg::pick_t pick
);

    localparam logic [31:0] HW_MASK    = 32'((64'd1 << HW_WARPS) - 64'd1);
    localparam logic [4:0]  START_WRAP = 5'(32 % HW_WARPS);

    logic [31:0] free_bits;
    logic [4:0]  start;
    logic [31:0] upper;
    logic [31:0] sel;
    logic [31:0] lowest;
    logic [4:0]  idx;

    assign free_bits = ~busy_mask & HW_MASK;

    // The reset value of the last warp sits outside a small pool, so it wraps
    // by the constant remainder.
    always_comb begin
        priority if (last_warp == 5'd31) begin
            start = START_WRAP;
        end else if (32'(last_warp) + 32'd1 == 32'(HW_WARPS)) begin
            start = 5'd0;
        end else begin
            start = last_warp + 5'd1;
        end
    end

    assign upper  = free_bits & ~((32'd1 << start) - 32'd1);
    assign sel    = (|upper) ? upper : free_bits;
    assign lowest = sel & (~sel + 32'd1);

    always_comb begin
        idx = 5'd0;
        for (int i = 0; i < 32; i++) begin
            if (lowest[i]) begin
                idx = idx | 5'(i);
            end
        end
    end

    assign pick.found = |free_bits;
    assign pick.warp  = idx;

endmodule

// ===== rtl/block_slot_barrier_tracker.sv =====
// ----------------------------------------------------------------------------
// Block slot barrier tracker
// Tracks thread blocks in the block slots of a GPU core: warp arrival,
// barrier synchronisation and warp end, one command word at a time.
// ----------------------------------------------------------------------------
// Flow: the slot entry is read when a command word is taken, then updated and
// written as the result word enters the output register, stalled until that
// register is free. A new word is taken only after that read-modify-write.
// Reset: valid bits of all slots, the warp busy mask and the output are
// cleared at once and the last assigned warp is set to 31; no clearing pass.
// ----------------------------------------------------------------------------
module block_slot_barrier_tracker #(
    parameter int SUBCORES          = bsbt_pkg::DEF_SUBCORES,
    parameter int WARPS_PER_SUBCORE = bsbt_pkg::DEF_WARPS_PER_SUBCORE,
    parameter int BLOCK_SLOTS       = bsbt_pkg::DEF_BLOCK_SLOTS,
    parameter int PC_BITS           = bsbt_pkg::DEF_PC_BITS
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  bsbt_pkg::in_word_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output bsbt_pkg::out_word_t m_data
);

    // The pool holds at most 32 hardware warps, and the three-bit slot index
    // reaches at most eight slots, so storage is sized to what can be named.
    localparam int HW_WARPS = (SUBCORES * WARPS_PER_SUBCORE > 32) ? 32
                                                                  : SUBCORES * WARPS_PER_SUBCORE;
    localparam int SLOT_D   = (BLOCK_SLOTS > 8) ? 8 : BLOCK_SLOTS;
    localparam int AW       = (SLOT_D > 1) ? $clog2(SLOT_D) : 1;
    localparam int PC_W     = (PC_BITS > 32) ? 32 : PC_BITS;
    localparam logic [31:0] HW_MASK = 32'((64'd1 << HW_WARPS) - 64'd1);

    // Sequencer states: waiting for a word, or updating the slot entry.
    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    // One slot entry as held in the RAM.
    typedef struct packed {
        logic            open;
        logic [5:0]      count;
        logic [31:0]     arrived;
        logic [31:0]     running;
        logic [PC_W-1:0] pc;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    logic                state_reg;
    logic                state_next;
    bsbt_pkg::in_word_t  item_reg;
    logic [SLOT_D-1:0]   slot_valid_reg;
    logic [31:0]         busy_reg;
    logic [31:0]         busy_next;
    logic [4:0]          last_reg;
    logic [4:0]          last_next;
    logic                m_valid_reg;
    bsbt_pkg::out_word_t m_data_reg;

    logic                accept;
    logic                out_free;
    logic                out_load;
    logic [ENTRY_W-1:0]  ram_rdata;
    logic [AW-1:0]       item_addr;
    entry_t              entry_cur;
    entry_t              entry_new;
    logic                entry_we;
    bsbt_pkg::pick_t     pick;
    bsbt_pkg::out_word_t res;

    logic                slot_ok;
    logic                warp_ok;
    logic [7:0]          hw_full;
    logic [31:0]         hbit;
    logic [31:0]         win;
    logic [31:0]         wib_bit;
    logic [31:0]         arrived_upd;
    logic [PC_W-1:0]     item_pc;
    logic [5:0]          count_dec;

    // ------------------------------------------------------------------------
    // Handshake. A new word is taken whenever no entry update is in flight,
    // even while the previous result still waits in the output register; the
    // update then stalls until that register frees up.
    // ------------------------------------------------------------------------
    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign out_load = (state_reg == ST_EXEC) && out_free;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // Slot RAM. The read is issued at the accepting edge and its data is held
    // until the next accept, so a stalled update still sees it. The write at
    // the end of the update lands before the next word can be read, so two
    // commands to the same slot never overlap and no forwarding is needed.
    // ------------------------------------------------------------------------
    assign item_addr = item_reg.slot_index[AW-1:0];

    bsbt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOT_D)
    ) u_slot_ram (
        .aclk  (aclk),
        .we    (entry_we),
        .waddr (item_addr),
        .wdata (entry_new),
        .re    (accept),
        .raddr (s_data.slot_index[AW-1:0]),
        .rdata (ram_rdata)
    );

    // An entry never written since reset reads as a closed, empty slot.
    assign slot_ok   = (32'(item_reg.slot_index) < 32'(BLOCK_SLOTS));
    assign entry_cur = (slot_ok && slot_valid_reg[item_addr]) ? entry_t'(ram_rdata)
                                                              : entry_t'('0);

    // ------------------------------------------------------------------------
    // Warp decode and the idle warp search.
    // ------------------------------------------------------------------------
    assign hw_full = 8'(item_reg.subcore_index) * 8'(WARPS_PER_SUBCORE)
                   + 8'(item_reg.local_warp);
    assign warp_ok = (32'(item_reg.subcore_index) < 32'(SUBCORES))
                  && (32'(item_reg.local_warp) < 32'(WARPS_PER_SUBCORE))
                  && (32'(hw_full) < 32'(HW_WARPS));
    assign hbit    = warp_ok ? (32'd1 << hw_full[4:0]) : 32'd0;

    assign win       = (entry_cur.count >= 6'd32) ? 32'hFFFF_FFFF
                                                  : ((32'd1 << entry_cur.count[4:0]) - 32'd1);
    assign wib_bit   = 32'd1 << item_reg.warp_in_block;
    assign arrived_upd = entry_cur.arrived | wib_bit;
    assign item_pc   = item_reg.barrier_pc[PC_W-1:0];
    assign count_dec = entry_cur.count - 6'd1;

    bsbt_warp_pick #(
        .HW_WARPS (HW_WARPS)
    ) u_warp_pick (
        .busy_mask (busy_reg),
        .last_warp (last_reg),
        .pick      (pick)
    );

    // ------------------------------------------------------------------------
    // Command execution: the entry is modified and the result word formed.
    // ------------------------------------------------------------------------
    always_comb begin
        entry_new = entry_cur;
        entry_we  = 1'b0;
        busy_next = busy_reg;
        last_next = last_reg;
        res       = '0;
        res.status = bsbt_pkg::STATUS_OK;

        priority if (item_reg.cmd == bsbt_pkg::CMD_NONE) begin
            // CMD_NONE: nothing changes.
        end else if (!slot_ok) begin
            res.status = bsbt_pkg::STATUS_BAD_SLOT;
        end else if (item_reg.cmd == bsbt_pkg::CMD_ARRIVE) begin
            if (!pick.found) begin
                res.status = bsbt_pkg::STATUS_NO_WARP;
            end else begin
                last_next = pick.warp;
                busy_next = busy_reg | (32'd1 << pick.warp);
                // Opening a closed slot starts it from empty; the barrier pc
                // is left as it was.
                if (!entry_cur.open) begin
                    entry_new.open    = 1'b1;
                    entry_new.count   = 6'd0;
                    entry_new.arrived = 32'd0;
                    entry_new.running = 32'd0;
                end
                entry_new.running = entry_new.running | (32'd1 << pick.warp);
                entry_new.count   = entry_new.count + 6'd1;
                entry_we          = 1'b1;
                res.assigned_warp = pick.warp;
            end
        end else if (!warp_ok || !entry_cur.open || entry_cur.count == 6'd0
                     || (entry_cur.running & hbit) == 32'd0) begin
            res.status = bsbt_pkg::STATUS_BAD_SLOT;
        end else if (item_reg.cmd == bsbt_pkg::CMD_BARRIER) begin
            priority if (entry_cur.count == 6'd1) begin
                // A block of one warp never waits at a barrier.
            end else if ((entry_cur.arrived & win) == 32'd0) begin
                // First warp to reach the barrier records its pc.
                entry_new.arrived = arrived_upd;
                entry_new.pc      = item_pc;
                entry_we          = 1'b1;
                res.hold_valid    = 1'b1;
                res.hold_warp     = hw_full[4:0];
            end else if (entry_cur.pc != item_pc) begin
                res.status = bsbt_pkg::STATUS_PC_MISMATCH;
            end else begin
                entry_new.arrived = arrived_upd;
                entry_we          = 1'b1;
                res.hold_valid    = 1'b1;
                res.hold_warp     = hw_full[4:0];
                // Last arrival: release every running warp of the block.
                if ((arrived_upd & win) == win) begin
                    entry_new.arrived = 32'd0;
                    res.release_mask  = entry_cur.running;
                end
            end
        end else begin
            res.finish_valid  = 1'b1;
            res.finish_slot   = item_reg.slot_index;
            res.finish_warp   = item_reg.warp_in_block;
            entry_new.count   = count_dec;
            entry_new.running = entry_cur.running & ~hbit;
            busy_next         = busy_reg & ~hbit;
            entry_we          = 1'b1;
            if (count_dec == 6'd0) begin
                entry_new.open    = 1'b0;
                entry_new.arrived = 32'd0;
                res.slot_freed    = 1'b1;
            end
        end

        // Only commit the update once the result can be handed over.
        entry_we = entry_we && out_load;
    end

    // ------------------------------------------------------------------------
    // Registers.
    // ------------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            slot_valid_reg <= '0;
            busy_reg       <= 32'd0;
            last_reg       <= 5'd31;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                busy_reg    <= busy_next;
                last_reg    <= last_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (entry_we) begin
                slot_valid_reg[item_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg <= s_data;
        end
        if (out_load) begin
            m_data_reg <= res;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // ------------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------------
    a_busy_in_pool: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg & ~HW_MASK) == 32'd0)
        else $error("busy mask holds a warp outside the pool");

    a_load_gives_word: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> m_valid)
        else $error("finished update did not present a result word");

    a_release_with_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && res.release_mask != 32'd0) |-> res.hold_valid)
        else $error("release without the releasing warp being held");

    a_assigned_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && item_reg.cmd == bsbt_pkg::CMD_ARRIVE
         && res.status == bsbt_pkg::STATUS_OK)
        |=> busy_reg[$past(res.assigned_warp)])
        else $error("assigned warp not marked busy");

    a_no_accept_in_update: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !out_free) |=> !s_ready)
        else $error("new word taken while an update is stalled");

endmodule
